>>> hdl/ucg_pkg.sv
// Shared types and constants for the uplink command gate.
// Used by ucg_ctrl, ucg_datapath and the top level; no dependencies.
package ucg_pkg;

  localparam int ACK_QUEUE_DEPTH_DEF = 4;
  localparam int RECENT_DEPTH_DEF    = 4;

  localparam int CODE_W  = 8;
  localparam int SEQ_W   = 16;
  localparam int NONCE_W = 32;
  localparam int TIME_W  = 32;
  localparam int PARAM_W = 16;
  localparam int KEY_W   = CODE_W + SEQ_W + NONCE_W;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DEPLOY_CODE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPRECATED_CODE = 8'd1;

  localparam logic [CODE_W-1:0] DEPLOY_CODE_RST     = 8'd1;
  localparam logic [CODE_W-1:0] DEPRECATED_CODE_RST = 8'd2;

  typedef enum logic [1:0] {
    STG_ACCEPTED  = 2'd0,
    STG_EXECUTED  = 2'd1,
    STG_REJECTED  = 2'd2,
    STG_DUPLICATE = 2'd3
  } ack_stage_t;

  typedef enum logic [2:0] {
    OUT_OK          = 3'd0,
    OUT_AUTH        = 3'd1,
    OUT_EXPIRED     = 3'd2,
    OUT_UNSUPPORTED = 3'd3,
    OUT_DONE        = 3'd4,
    OUT_BADFMT      = 3'd5
  } ack_outcome_t;

  typedef enum logic [2:0] {
    WHY_NONE       = 3'd0,
    WHY_TAG        = 3'd1,
    WHY_EXPIRED    = 3'd2,
    WHY_INHIBIT    = 3'd3,
    WHY_DEPRECATED = 3'd4,
    WHY_UNKNOWN    = 3'd5
  } ack_reason_t;

  typedef enum logic [3:0] {
    DEC_IGNORE,
    DEC_POP,
    DEC_AUTH,
    DEC_EXPIRED,
    DEC_DUP,
    DEC_BADFMT,
    DEC_DEPLOY,
    DEC_DEPRECATED,
    DEC_UNKNOWN
  } dec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]         stage;
    logic [2:0]         outcome;
    logic [2:0]         reason;
    logic               flight;
    logic [CODE_W-1:0]  code;
    logic [SEQ_W-1:0]   seq;
    logic [NONCE_W-1:0] nonce;
    logic [TIME_W-1:0]  stamp;
  } ack_entry_t;

  typedef struct packed {
    logic load_in;
    logic do_first;
    logic do_second;
    logic load_out;
  } ucg_cmd_t;

  typedef struct packed {
    logic two_push;
    logic out_free;
  } ucg_stat_t;

endpackage

>>> hdl/ucg_ctrl.sv
// Controller state machine for the uplink command gate.
// Depends on ucg_pkg; drives commands into ucg_datapath from its status.
module ucg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ucg_pkg::ucg_stat_t  stat,
  output ucg_pkg::ucg_cmd_t   cmd
);

  ucg_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ucg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ucg_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = ucg_pkg::ST_EVAL;
      end
      ucg_pkg::ST_EVAL: begin
        if (stat.two_push) state_nxt = ucg_pkg::ST_EXEC;
        else if (stat.out_free) state_nxt = ucg_pkg::ST_IDLE;
      end
      ucg_pkg::ST_EXEC: begin
        if (stat.out_free) state_nxt = ucg_pkg::ST_IDLE;
      end
      default: state_nxt = ucg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ucg_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ucg_pkg::ST_EVAL: begin
        cmd.do_first = stat.two_push | stat.out_free;
        cmd.load_out = !stat.two_push & stat.out_free;
      end
      ucg_pkg::ST_EXEC: begin
        cmd.do_second = stat.out_free;
        cmd.load_out  = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> hdl/ucg_datapath.sv
// Datapath of the uplink command gate: input latch, checks, replay keys,
// ack FIFO and result register. Depends on ucg_pkg; driven by ucg_ctrl.
module ucg_datapath #(
  parameter int ACK_QUEUE_DEPTH = ucg_pkg::ACK_QUEUE_DEPTH_DEF,
  parameter int RECENT_DEPTH    = ucg_pkg::RECENT_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ucg_pkg::ucg_cmd_t                  cmd,
  output ucg_pkg::ucg_stat_t                 stat,
  input  logic                               cfg_valid,
  input  logic [ucg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ucg_pkg::CODE_W-1:0]         cfg_data,
  input  logic                               in_action,
  input  logic                               in_is_command,
  input  logic                               in_auth_ok,
  input  logic [ucg_pkg::CODE_W-1:0]         in_command_code,
  input  logic [ucg_pkg::SEQ_W-1:0]          in_command_seq,
  input  logic [ucg_pkg::NONCE_W-1:0]        in_command_nonce,
  input  logic [ucg_pkg::TIME_W-1:0]         in_valid_until,
  input  logic [ucg_pkg::PARAM_W-1:0]        in_first_param,
  input  logic [ucg_pkg::TIME_W-1:0]         in_now_time,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_ack_valid,
  output logic [1:0]                         out_ack_stage,
  output logic [2:0]                         out_ack_outcome,
  output logic [2:0]                         out_ack_reason,
  output logic                               out_ack_flight_state,
  output logic [ucg_pkg::CODE_W-1:0]         out_ack_command_code,
  output logic [ucg_pkg::SEQ_W-1:0]          out_ack_command_seq,
  output logic [ucg_pkg::NONCE_W-1:0]        out_ack_nonce,
  output logic [ucg_pkg::TIME_W-1:0]         out_ack_time,
  output logic [1:0]                         out_acks_dropped,
  output logic                               out_deploy_active
);

  localparam int QAW = $clog2(ACK_QUEUE_DEPTH);
  localparam int CW  = $clog2(ACK_QUEUE_DEPTH + 1);
  localparam int SW  = QAW + 1;
  localparam int RAW = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;

  // config
  logic [ucg_pkg::CODE_W-1:0] deploy_code_r, depr_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deploy_code_r <= ucg_pkg::DEPLOY_CODE_RST;
      depr_code_r   <= ucg_pkg::DEPRECATED_CODE_RST;
    end else if (cfg_valid) begin
      if (cfg_index == ucg_pkg::REG_DEPLOY_CODE) deploy_code_r <= cfg_data;
      if (cfg_index == ucg_pkg::REG_DEPRECATED_CODE) depr_code_r <= cfg_data;
    end
  end

  // input latch
  logic                        act_r, iscmd_r, auth_r;
  logic [ucg_pkg::CODE_W-1:0]  code_r;
  logic [ucg_pkg::SEQ_W-1:0]   seq_r;
  logic [ucg_pkg::NONCE_W-1:0] nonce_r;
  logic [ucg_pkg::TIME_W-1:0]  until_r, now_r;
  logic [ucg_pkg::PARAM_W-1:0] param_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r   <= in_action;
      iscmd_r <= in_is_command;
      auth_r  <= in_auth_ok;
      code_r  <= in_command_code;
      seq_r   <= in_command_seq;
      nonce_r <= in_command_nonce;
      until_r <= in_valid_until;
      param_r <= in_first_param;
      now_r   <= in_now_time;
    end
  end

  // replay keys
  logic [RECENT_DEPTH-1:0]        rec_valid_r;
  logic [ucg_pkg::KEY_W-1:0]      rec_key_r [RECENT_DEPTH];
  logic [RAW-1:0]                 rec_ptr_r;
  logic [ucg_pkg::KEY_W-1:0]      key;
  logic [RECENT_DEPTH-1:0]        hit;
  logic                           seen;

  assign key = {nonce_r, seq_r, code_r};

  always_comb begin
    for (int i = 0; i < RECENT_DEPTH; i++) begin
      hit[i] = rec_valid_r[i] && (rec_key_r[i] == key);
    end
  end
  assign seen = |hit;

  // deadline and decision
  logic [ucg_pkg::TIME_W-1:0] diff;
  logic                       expired;
  ucg_pkg::dec_t              dec;

  assign diff    = now_r - until_r;
  assign expired = (until_r != '0) && (diff != '0) && !diff[ucg_pkg::TIME_W-1];

  always_comb begin
    if (act_r) dec = ucg_pkg::DEC_POP;
    else if (!iscmd_r) dec = ucg_pkg::DEC_IGNORE;
    else if (!auth_r) dec = ucg_pkg::DEC_AUTH;
    else if (expired) dec = ucg_pkg::DEC_EXPIRED;
    else if (seen) dec = ucg_pkg::DEC_DUP;
    else if (code_r == deploy_code_r) begin
      dec = (param_r != '0) ? ucg_pkg::DEC_BADFMT : ucg_pkg::DEC_DEPLOY;
    end
    else if (code_r == depr_code_r) dec = ucg_pkg::DEC_DEPRECATED;
    else dec = ucg_pkg::DEC_UNKNOWN;
  end

  // ack FIFO
  ucg_pkg::ack_entry_t q_mem [ACK_QUEUE_DEPTH];
  logic [QAW-1:0]      head_r, tail, head_inc;
  logic [CW-1:0]       count_r;
  logic [SW-1:0]       tail_sum;
  logic                q_full, push_req, push_ok, push_drop, pop_ok;
  ucg_pkg::ack_entry_t push_entry;
  logic                deploy_r, deploy_nxt, drop_r, remember;

  assign tail_sum = SW'(head_r) + SW'(count_r);
  assign tail     = (tail_sum >= SW'(ACK_QUEUE_DEPTH)) ?
                    QAW'(tail_sum - SW'(ACK_QUEUE_DEPTH)) : QAW'(tail_sum);
  assign head_inc = (head_r == QAW'(ACK_QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign q_full   = (count_r == CW'(ACK_QUEUE_DEPTH));

  always_comb begin
    push_entry.flight = deploy_r;
    push_entry.code   = code_r;
    push_entry.seq    = seq_r;
    push_entry.nonce  = nonce_r;
    push_entry.stamp  = now_r;
    push_req          = cmd.do_second;
    if (cmd.do_second) begin
      push_entry.stage   = ucg_pkg::STG_EXECUTED;
      push_entry.outcome = ucg_pkg::OUT_OK;
      push_entry.reason  = ucg_pkg::WHY_NONE;
    end else begin
      push_req           = cmd.do_first;
      push_entry.stage   = ucg_pkg::STG_REJECTED;
      push_entry.outcome = ucg_pkg::OUT_UNSUPPORTED;
      push_entry.reason  = ucg_pkg::WHY_UNKNOWN;
      case (dec)
        ucg_pkg::DEC_POP, ucg_pkg::DEC_IGNORE: begin
          push_req = 1'b0;
        end
        ucg_pkg::DEC_AUTH: begin
          push_entry.outcome = ucg_pkg::OUT_AUTH;
          push_entry.reason  = ucg_pkg::WHY_TAG;
        end
        ucg_pkg::DEC_EXPIRED: begin
          push_entry.outcome = ucg_pkg::OUT_EXPIRED;
          push_entry.reason  = ucg_pkg::WHY_EXPIRED;
        end
        ucg_pkg::DEC_DUP: begin
          push_entry.stage   = ucg_pkg::STG_DUPLICATE;
          push_entry.outcome = ucg_pkg::OUT_DONE;
          push_entry.reason  = ucg_pkg::WHY_NONE;
        end
        ucg_pkg::DEC_BADFMT: begin
          push_entry.outcome = ucg_pkg::OUT_BADFMT;
          push_entry.reason  = ucg_pkg::WHY_INHIBIT;
        end
        ucg_pkg::DEC_DEPLOY: begin
          push_entry.stage   = ucg_pkg::STG_ACCEPTED;
          push_entry.outcome = ucg_pkg::OUT_OK;
          push_entry.reason  = ucg_pkg::WHY_NONE;
        end
        ucg_pkg::DEC_DEPRECATED: begin
          push_entry.reason  = ucg_pkg::WHY_DEPRECATED;
        end
        default: begin
          push_entry.reason  = ucg_pkg::WHY_UNKNOWN;
        end
      endcase
    end
  end

  assign push_ok    = push_req && !q_full;
  assign push_drop  = push_req && q_full;
  assign pop_ok     = cmd.do_first && (dec == ucg_pkg::DEC_POP) && (count_r != '0);
  assign deploy_nxt = deploy_r | (cmd.do_first && (dec == ucg_pkg::DEC_DEPLOY));
  assign remember   = cmd.do_first &&
                      ((dec == ucg_pkg::DEC_DEPLOY) || (dec == ucg_pkg::DEC_DEPRECATED));

  always_ff @(posedge clk) begin
    if (push_ok) q_mem[tail] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      deploy_r    <= 1'b0;
      rec_valid_r <= '0;
      rec_ptr_r   <= '0;
    end else begin
      deploy_r <= deploy_nxt;
      if (push_ok) count_r <= count_r + 1'b1;
      else if (pop_ok) begin
        count_r <= count_r - 1'b1;
        head_r  <= head_inc;
      end
      if (remember) begin
        rec_valid_r[rec_ptr_r] <= 1'b1;
        rec_ptr_r <= (rec_ptr_r == RAW'(RECENT_DEPTH - 1)) ? '0 : rec_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (remember) rec_key_r[rec_ptr_r] <= key;
    if (cmd.do_first) drop_r <= push_drop;
  end

  // result register
  logic out_valid_r;

  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.two_push = (dec == ucg_pkg::DEC_DEPLOY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_deploy_active <= deploy_nxt;
      out_acks_dropped  <= cmd.do_second ? ({1'b0, drop_r} + {1'b0, push_drop})
                                         : {1'b0, push_drop};
      if (pop_ok) begin
        out_ack_valid        <= 1'b1;
        out_ack_stage        <= q_mem[head_r].stage;
        out_ack_outcome      <= q_mem[head_r].outcome;
        out_ack_reason       <= q_mem[head_r].reason;
        out_ack_flight_state <= q_mem[head_r].flight;
        out_ack_command_code <= q_mem[head_r].code;
        out_ack_command_seq  <= q_mem[head_r].seq;
        out_ack_nonce        <= q_mem[head_r].nonce;
        out_ack_time         <= q_mem[head_r].stamp;
      end else begin
        out_ack_valid        <= 1'b0;
        out_ack_stage        <= '0;
        out_ack_outcome      <= '0;
        out_ack_reason       <= '0;
        out_ack_flight_state <= 1'b0;
        out_ack_command_code <= '0;
        out_ack_command_seq  <= '0;
        out_ack_nonce        <= '0;
        out_ack_time         <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hdl/uplink_command_gate_with_replay_filter_unit.sv
// Top level of the uplink command gate with replay filter.
// Depends on ucg_pkg; instantiates ucg_ctrl and ucg_datapath.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | action, is_command, auth_ok, command key,
//           |                      | valid_until, first_param, now_time
//   out     | out_valid/out_ready  | ack fields, acks_dropped, deploy_active
//   cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
// An item passes through an accept and an evaluate step; a successful deploy adds an execute step,
// since its two acks go through the single FIFO write port one at a time.
// The next item is taken while a finished result waits in the output register.
// A held output stalls the evaluate step of the following item, or its execute step for a successful deploy.
// Reset is synchronous; no clearing pass is needed.
module uplink_command_gate_with_replay_filter_unit #(
  parameter int ACK_QUEUE_DEPTH = ucg_pkg::ACK_QUEUE_DEPTH_DEF,
  parameter int RECENT_DEPTH    = ucg_pkg::RECENT_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ucg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ucg_pkg::CODE_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_action,
  input  logic                               in_is_command,
  input  logic                               in_auth_ok,
  input  logic [ucg_pkg::CODE_W-1:0]         in_command_code,
  input  logic [ucg_pkg::SEQ_W-1:0]          in_command_seq,
  input  logic [ucg_pkg::NONCE_W-1:0]        in_command_nonce,
  input  logic [ucg_pkg::TIME_W-1:0]         in_valid_until,
  input  logic [ucg_pkg::PARAM_W-1:0]        in_first_param,
  input  logic [ucg_pkg::TIME_W-1:0]         in_now_time,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_ack_valid,
  output logic [1:0]                         out_ack_stage,
  output logic [2:0]                         out_ack_outcome,
  output logic [2:0]                         out_ack_reason,
  output logic                               out_ack_flight_state,
  output logic [ucg_pkg::CODE_W-1:0]         out_ack_command_code,
  output logic [ucg_pkg::SEQ_W-1:0]          out_ack_command_seq,
  output logic [ucg_pkg::NONCE_W-1:0]        out_ack_nonce,
  output logic [ucg_pkg::TIME_W-1:0]         out_ack_time,
  output logic [1:0]                         out_acks_dropped,
  output logic                               out_deploy_active
);

  ucg_pkg::ucg_cmd_t  cmd;
  ucg_pkg::ucg_stat_t stat;

  assign cfg_ready = 1'b1;

  ucg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ucg_datapath #(
    .ACK_QUEUE_DEPTH (ACK_QUEUE_DEPTH),
    .RECENT_DEPTH    (RECENT_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_valid            (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_action            (in_action),
    .in_is_command        (in_is_command),
    .in_auth_ok           (in_auth_ok),
    .in_command_code      (in_command_code),
    .in_command_seq       (in_command_seq),
    .in_command_nonce     (in_command_nonce),
    .in_valid_until       (in_valid_until),
    .in_first_param       (in_first_param),
    .in_now_time          (in_now_time),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_ack_valid        (out_ack_valid),
    .out_ack_stage        (out_ack_stage),
    .out_ack_outcome      (out_ack_outcome),
    .out_ack_reason       (out_ack_reason),
    .out_ack_flight_state (out_ack_flight_state),
    .out_ack_command_code (out_ack_command_code),
    .out_ack_command_seq  (out_ack_command_seq),
    .out_ack_nonce        (out_ack_nonce),
    .out_ack_time         (out_ack_time),
    .out_acks_dropped     (out_acks_dropped),
    .out_deploy_active    (out_deploy_active)
  );

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before the beat was evaluated");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded over an untaken beat");

  a_single_push: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.do_first && cmd.do_second))
    else $error("both ack pushes in one cycle");

  a_deploy_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out && $past(out_valid && out_deploy_active) |=> out_deploy_active)
    else $error("deploy flag cleared");

endmodule

>>> tb/tb_top.sv
// Self-checking bench for uplink_command_gate_with_replay_filter_unit: directed table, then
// random phases under several code settings; depends on ucg_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb_top;

  localparam int LIMIT = 400000;
  localparam int ITEMS = 1450;
  localparam int QDEPTH = ucg_pkg::ACK_QUEUE_DEPTH_DEF;
  localparam int KEYS = ucg_pkg::RECENT_DEPTH_DEF;

  typedef logic [ucg_pkg::CODE_W-1:0]  code_t;
  typedef logic [ucg_pkg::SEQ_W-1:0]   seq_t;
  typedef logic [ucg_pkg::PARAM_W-1:0] param_t;

  typedef struct {
    logic                        action;
    logic                        is_cmd;
    logic                        auth;
    logic [ucg_pkg::CODE_W-1:0]  code;
    logic [ucg_pkg::SEQ_W-1:0]   seq;
    logic [ucg_pkg::NONCE_W-1:0] nonce;
    logic [ucg_pkg::TIME_W-1:0]  deadline;
    logic [ucg_pkg::PARAM_W-1:0] param;
    logic [ucg_pkg::TIME_W-1:0]  now;
  } cmd_t;

  typedef struct packed {
    logic                ack_valid;
    ucg_pkg::ack_entry_t ack;
    logic [1:0]          dropped;
    logic                deploy;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ucg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ucg_pkg::CODE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = 1'b0;
  logic in_is_command = 1'b0;
  logic in_auth_ok = 1'b0;
  logic [ucg_pkg::CODE_W-1:0] in_command_code = '0;
  logic [ucg_pkg::SEQ_W-1:0] in_command_seq = '0;
  logic [ucg_pkg::NONCE_W-1:0] in_command_nonce = '0;
  logic [ucg_pkg::TIME_W-1:0] in_valid_until = '0;
  logic [ucg_pkg::PARAM_W-1:0] in_first_param = '0;
  logic [ucg_pkg::TIME_W-1:0] in_now_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_ack_valid;
  logic [1:0] out_ack_stage;
  logic [2:0] out_ack_outcome;
  logic [2:0] out_ack_reason;
  logic out_ack_flight_state;
  logic [ucg_pkg::CODE_W-1:0] out_ack_command_code;
  logic [ucg_pkg::SEQ_W-1:0] out_ack_command_seq;
  logic [ucg_pkg::NONCE_W-1:0] out_ack_nonce;
  logic [ucg_pkg::TIME_W-1:0] out_ack_time;
  logic [1:0] out_acks_dropped;
  logic out_deploy_active;

  uplink_command_gate_with_replay_filter_unit uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_is_command(in_is_command), .in_auth_ok(in_auth_ok),
    .in_command_code(in_command_code), .in_command_seq(in_command_seq),
    .in_command_nonce(in_command_nonce), .in_valid_until(in_valid_until),
    .in_first_param(in_first_param), .in_now_time(in_now_time),
    .out_valid(out_valid), .out_ready(out_ready), .out_ack_valid(out_ack_valid),
    .out_ack_stage(out_ack_stage), .out_ack_outcome(out_ack_outcome),
    .out_ack_reason(out_ack_reason), .out_ack_flight_state(out_ack_flight_state),
    .out_ack_command_code(out_ack_command_code), .out_ack_command_seq(out_ack_command_seq),
    .out_ack_nonce(out_ack_nonce), .out_ack_time(out_ack_time),
    .out_acks_dropped(out_acks_dropped), .out_deploy_active(out_deploy_active)
  );

  // gate state mirror
  logic [ucg_pkg::CODE_W-1:0] deploy_code;
  logic [ucg_pkg::CODE_W-1:0] deprecated_code;
  ucg_pkg::ack_entry_t ack_fifo[$];
  logic seen_vld[KEYS];
  logic [ucg_pkg::KEY_W-1:0] seen_key[KEYS];
  int seen_ptr;
  logic deploy_fired;

  reply_t due_replies[$];
  reply_t seen_reply;
  int errors = 0;
  int cyc = 0;

  cmd_t dir_cmd[$];
  bit dir_typed[$];
  reply_t dir_want[$];

  logic [ucg_pkg::TIME_W-1:0] now_ms;
  logic [ucg_pkg::KEY_W-1:0] key_pool[$];
  int counted;

  int hold_left = 0;
  int seg_left = 0;
  int stall_pct = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: segmented stall pattern plus periodic long hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (cyc % 3000 == 1500) begin
      out_ready <= 1'b0;
      hold_left <= 80;
    end else begin
      if (seg_left == 0) begin
        seg_left <= $urandom_range(4, 40);
        case ($urandom_range(0, 3))
          0: stall_pct <= 0;
          1: stall_pct <= 25;
          2: stall_pct <= 60;
          default: stall_pct <= 90;
        endcase
      end else begin
        seg_left <= seg_left - 1;
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cyc);
  endtask

  task automatic check_reply(reply_t got, reply_t want);
    if (got.ack_valid !== want.ack_valid) report("ack_valid", got.ack_valid, want.ack_valid);
    if (got.ack.stage !== want.ack.stage) report("ack_stage", got.ack.stage, want.ack.stage);
    if (got.ack.outcome !== want.ack.outcome)
      report("ack_outcome", got.ack.outcome, want.ack.outcome);
    if (got.ack.reason !== want.ack.reason) report("ack_reason", got.ack.reason, want.ack.reason);
    if (got.ack.flight !== want.ack.flight) report("ack_flight", got.ack.flight, want.ack.flight);
    if (got.ack.code !== want.ack.code) report("ack_code", got.ack.code, want.ack.code);
    if (got.ack.seq !== want.ack.seq) report("ack_seq", got.ack.seq, want.ack.seq);
    if (got.ack.nonce !== want.ack.nonce) report("ack_nonce", got.ack.nonce, want.ack.nonce);
    if (got.ack.stamp !== want.ack.stamp) report("ack_time", got.ack.stamp, want.ack.stamp);
    if (got.dropped !== want.dropped) report("acks_dropped", got.dropped, want.dropped);
    if (got.deploy !== want.deploy) report("deploy_active", got.deploy, want.deploy);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_reply.ack_valid = out_ack_valid;
      seen_reply.ack.stage = out_ack_stage;
      seen_reply.ack.outcome = out_ack_outcome;
      seen_reply.ack.reason = out_ack_reason;
      seen_reply.ack.flight = out_ack_flight_state;
      seen_reply.ack.code = out_ack_command_code;
      seen_reply.ack.seq = out_ack_command_seq;
      seen_reply.ack.nonce = out_ack_nonce;
      seen_reply.ack.stamp = out_ack_time;
      seen_reply.dropped = out_acks_dropped;
      seen_reply.deploy = out_deploy_active;
      if (due_replies.size() == 0)
        report("beat with nothing due", 0, 0);
      else
        check_reply(seen_reply, due_replies.pop_front());
    end
  end

  task automatic push_ack(ucg_pkg::ack_stage_t st, ucg_pkg::ack_outcome_t oc,
                          ucg_pkg::ack_reason_t why, cmd_t c, inout logic [1:0] drop);
    ucg_pkg::ack_entry_t e;
    if (ack_fifo.size() >= QDEPTH) begin
      drop = drop + 2'd1;
    end else begin
      e.stage = st;
      e.outcome = oc;
      e.reason = why;
      e.flight = deploy_fired;
      e.code = c.code;
      e.seq = c.seq;
      e.nonce = c.nonce;
      e.stamp = c.now;
      ack_fifo.push_back(e);
    end
  endtask

  task automatic remember(logic [ucg_pkg::KEY_W-1:0] key);
    seen_vld[seen_ptr] = 1'b1;
    seen_key[seen_ptr] = key;
    seen_ptr = (seen_ptr + 1) % KEYS;
  endtask

  task automatic evaluate_gate(cmd_t c, output reply_t r);
    logic [ucg_pkg::TIME_W-1:0] diff;
    logic [ucg_pkg::KEY_W-1:0] key;
    logic [1:0] drop;
    bit hit;
    r = '0;
    drop = 2'd0;
    if (c.action) begin
      if (ack_fifo.size() > 0) begin
        r.ack_valid = 1'b1;
        r.ack = ack_fifo.pop_front();
      end
    end else if (c.is_cmd) begin
      diff = c.now - c.deadline;
      key = {c.nonce, c.seq, c.code};
      hit = 0;
      for (int i = 0; i < KEYS; i++)
        if (seen_vld[i] && seen_key[i] == key) hit = 1;
      if (!c.auth) begin
        push_ack(ucg_pkg::STG_REJECTED, ucg_pkg::OUT_AUTH, ucg_pkg::WHY_TAG, c, drop);
      end else if (c.deadline != 0 && diff != 0 && !diff[ucg_pkg::TIME_W-1]) begin
        push_ack(ucg_pkg::STG_REJECTED, ucg_pkg::OUT_EXPIRED, ucg_pkg::WHY_EXPIRED, c, drop);
      end else if (hit) begin
        push_ack(ucg_pkg::STG_DUPLICATE, ucg_pkg::OUT_DONE, ucg_pkg::WHY_NONE, c, drop);
      end else if (c.code == deploy_code) begin
        if (c.param != 0) begin
          push_ack(ucg_pkg::STG_REJECTED, ucg_pkg::OUT_BADFMT, ucg_pkg::WHY_INHIBIT, c, drop);
        end else begin
          push_ack(ucg_pkg::STG_ACCEPTED, ucg_pkg::OUT_OK, ucg_pkg::WHY_NONE, c, drop);
          deploy_fired = 1'b1;
          remember(key);
          push_ack(ucg_pkg::STG_EXECUTED, ucg_pkg::OUT_OK, ucg_pkg::WHY_NONE, c, drop);
        end
      end else if (c.code == deprecated_code) begin
        remember(key);
        push_ack(ucg_pkg::STG_REJECTED, ucg_pkg::OUT_UNSUPPORTED, ucg_pkg::WHY_DEPRECATED, c,
                 drop);
      end else begin
        push_ack(ucg_pkg::STG_REJECTED, ucg_pkg::OUT_UNSUPPORTED, ucg_pkg::WHY_UNKNOWN, c,
                 drop);
      end
    end
    r.dropped = drop;
    r.deploy = deploy_fired;
  endtask

  function automatic cmd_t mk(logic act, logic isc, logic auth,
                              logic [ucg_pkg::CODE_W-1:0] code,
                              logic [ucg_pkg::SEQ_W-1:0] seq,
                              logic [ucg_pkg::NONCE_W-1:0] nonce,
                              logic [ucg_pkg::TIME_W-1:0] dl,
                              logic [ucg_pkg::PARAM_W-1:0] param,
                              logic [ucg_pkg::TIME_W-1:0] now);
    cmd_t c;
    c.action = act;
    c.is_cmd = isc;
    c.auth = auth;
    c.code = code;
    c.seq = seq;
    c.nonce = nonce;
    c.deadline = dl;
    c.param = param;
    c.now = now;
    return c;
  endfunction

  function automatic reply_t bare_reply(logic [1:0] drop, logic dep);
    reply_t r;
    r = '0;
    r.dropped = drop;
    r.deploy = dep;
    return r;
  endfunction

  task automatic row(cmd_t c, bit typed, reply_t want);
    dir_cmd.push_back(c);
    dir_typed.push_back(typed);
    dir_want.push_back(want);
  endtask

  task automatic offer(cmd_t c, bit typed, reply_t want);
    reply_t pred;
    in_valid <= 1'b1;
    in_action <= c.action;
    in_is_command <= c.is_cmd;
    in_auth_ok <= c.auth;
    in_command_code <= c.code;
    in_command_seq <= c.seq;
    in_command_nonce <= c.nonce;
    in_valid_until <= c.deadline;
    in_first_param <= c.param;
    in_now_time <= c.now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    evaluate_gate(c, pred);
    due_replies.push_back(typed ? want : pred);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_codes(logic [ucg_pkg::CODE_W-1:0] dep,
                             logic [ucg_pkg::CODE_W-1:0] depr);
    cfg_valid <= 1'b1;
    cfg_index <= ucg_pkg::REG_DEPLOY_CODE;
    cfg_data <= dep;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    deploy_code = dep;
    cfg_index <= ucg_pkg::REG_DEPRECATED_CODE;
    cfg_data <= depr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    deprecated_code = depr;
    cfg_valid <= 1'b0;
  endtask

  task automatic next_command(output cmd_t c);
    logic [ucg_pkg::KEY_W-1:0] k;
    int pick;
    c = mk(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
           code_t'($urandom), seq_t'($urandom), $urandom, $urandom, param_t'($urandom),
           $urandom);
    if ($urandom_range(0, 49) == 0)
      now_ms = $urandom;
    else
      now_ms = now_ms + $urandom_range(0, 40);
    c.now = now_ms;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      c.action = 1'b1;
      return;
    end
    c.action = 1'b0;
    if (pick < 44) begin
      c.is_cmd = 1'b0;
      return;
    end
    c.is_cmd = 1'b1;
    c.auth = ($urandom_range(0, 19) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 30) c.code = deploy_code;
    else if (pick < 45) c.code = deprecated_code;
    else if (pick < 65) c.code = code_t'($urandom_range(0, 7));
    if (key_pool.size() > 0 && $urandom_range(0, 3) == 0) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      {c.nonce, c.seq, c.code} = k;
    end
    key_pool.push_back({c.nonce, c.seq, c.code});
    if (key_pool.size() > 8) void'(key_pool.pop_front());
    pick = $urandom_range(0, 99);
    if (pick < 40) c.deadline = '0;
    else if (pick < 68) c.deadline = now_ms + $urandom_range(1, 5000);
    else if (pick < 76) c.deadline = now_ms;
    else if (pick < 90) c.deadline = now_ms - $urandom_range(1, 5000);
    else if (pick < 93) c.deadline = now_ms - 32'h8000_0000;
    else if (pick < 96) c.deadline = now_ms - 32'h7FFF_FFFF;
    if (c.code == deploy_code)
      c.param = ($urandom_range(0, 9) < 7) ? '0 : c.param;
    else if ($urandom_range(0, 1) == 0)
      c.param = '0;
  endtask

  initial begin
    cmd_t c;
    int burst_left;
    int target;
    deploy_code = ucg_pkg::DEPLOY_CODE_RST;
    deprecated_code = ucg_pkg::DEPRECATED_CODE_RST;
    for (int i = 0; i < KEYS; i++) seen_vld[i] = 1'b0;
    seen_ptr = 0;
    deploy_fired = 1'b0;
    now_ms = 32'hFFFF_F000;
    counted = 0;

    row(mk(1, 0, 0, 8'h00, 16'h0000, 32'h0, 32'h0, 16'h0, 32'h0), 1, bare_reply(0, 0));
    row(mk(0, 0, 1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF),
        1, bare_reply(0, 0));
    row(mk(0, 1, 0, 8'h55, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 16'h0, 32'd100), 1, bare_reply(0, 0));
    row(mk(1, 0, 0, 8'h00, 16'h0000, 32'h0, 32'h0, 16'h0, 32'd100), 1,
        {1'b1, ucg_pkg::STG_REJECTED, ucg_pkg::OUT_AUTH, ucg_pkg::WHY_TAG, 1'b0, 8'h55,
         16'hFFFF, 32'hFFFF_FFFF, 32'd100, 2'd0, 1'b0});
    row(mk(0, 1, 1, 8'h10, 16'h0001, 32'h1, 32'd100, 16'h0, 32'd101), 0, '0);
    row(mk(0, 1, 1, 8'hFF, 16'h0000, 32'h0, 32'h0, 16'hFFFF, 32'hFFFF_FFFF), 0, '0);
    row(mk(0, 1, 1, 8'h00, 16'h1234, 32'h0, 32'h500, 16'h0, 32'h500), 0, '0);
    row(mk(0, 1, 1, 8'h03, 16'h0003, 32'h3, 32'hFFFF_FFF0, 16'h0, 32'h10), 0, '0);
    row(mk(0, 1, 1, 8'h04, 16'h0004, 32'h4, 32'h8000_0010, 16'h0, 32'h10), 1, bare_reply(1, 0));
    for (int i = 0; i < 4; i++) row(mk(1, 0, 0, 0, 0, 0, 0, 0, 32'd150), 0, '0);
    row(mk(0, 1, 1, 8'h01, 16'h0001, 32'hA5A5_A5A5, 32'h0, 16'hFFFF, 32'd200), 0, '0);
    row(mk(0, 1, 1, 8'h02, 16'h0002, 32'h5A5A_5A5A, 32'h0, 16'h0, 32'd201), 0, '0);
    row(mk(0, 1, 1, 8'h02, 16'h0002, 32'h5A5A_5A5A, 32'h0, 16'h0, 32'd202), 0, '0);
    row(mk(0, 1, 1, 8'h01, 16'h0007, 32'hDEAD_BEEF, 32'h0, 16'h0, 32'd203), 0, '0);
    row(mk(0, 1, 1, 8'h01, 16'h0008, 32'h0, 32'h0, 16'h0, 32'd204), 1, bare_reply(2, 1));
    row(mk(0, 1, 1, 8'h01, 16'h0007, 32'hDEAD_BEEF, 32'h0, 16'h0, 32'd205), 0, '0);
    for (int i = 0; i < 4; i++) row(mk(1, 0, 0, 0, 0, 0, 0, 0, 32'd210), 0, '0);
    row(mk(1, 0, 0, 0, 0, 0, 0, 0, 32'd220), 1, bare_reply(0, 1));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < dir_cmd.size(); i++) begin
      offer(dir_cmd[i], dir_typed[i], dir_want[i]);
      idle_gap($urandom_range(0, 2));
    end

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: write_codes(8'h00, 8'hFF);
        1: write_codes(8'hFF, 8'h00);
        2: begin
          target = $urandom_range(0, 255);
          write_codes(code_t'(target), code_t'(target));
        end
        3: write_codes(code_t'($urandom), code_t'($urandom));
        default: write_codes(ucg_pkg::DEPLOY_CODE_RST, ucg_pkg::DEPRECATED_CODE_RST);
      endcase
      target = ITEMS * (ph + 1) / 5;
      burst_left = $urandom_range(1, 24);
      while (counted < target) begin
        next_command(c);
        offer(c, 0, '0);
        if (c.action || c.is_cmd) begin
          counted++;
          if (counted % 200 == 100) drain();
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
        end else begin
          burst_left--;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (due_replies.size() != 0) report("beats never seen", due_replies.size(), 0);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
